FILE: src/smf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// smf_pkg: shared types and constants of the scan median filter
// Sample width, window geometry, request/response words and the fill
// control that passes from the window stage to the result queue.
// ---------------------------------------------------------------------------
package smf_pkg;

   localparam int SAMPLE_BITS = 16;
   localparam int WINDOW      = 5;
   localparam int HALF        = WINDOW / 2;
   localparam int LAG         = WINDOW - 1 - HALF;
   localparam int HIST_DEPTH  = WINDOW - 1;
   localparam int MAX_RES     = LAG + 1;

   localparam int RANK_W = $clog2(WINDOW);
   localparam int SEEN_W = $clog2(HIST_DEPTH + 1);
   localparam int CNT_W  = $clog2(MAX_RES + 1);

   typedef logic [SAMPLE_BITS-1:0] sample_type;
   typedef sample_type [WINDOW-1:0] smf_win_type;

   typedef struct packed {
      logic [SAMPLE_BITS-1:0] range_in;
      logic                   last_in;
   } smf_req_type;

   typedef struct packed {
      logic [SAMPLE_BITS-1:0] range_out;
      logic                   last_out;
   } smf_rsp_type;

   typedef smf_rsp_type [MAX_RES-1:0] smf_rsp_vec_type;

   typedef struct packed {
      logic             load;
      logic [CNT_W-1:0] count;
   } smf_fill_type;

endpackage
`default_nettype wire

FILE: src/smf_median.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// smf_median: median of one full window
// Ranks every sample against all others in parallel (ties broken by
// position) and selects the sample whose rank is the middle one.
// ---------------------------------------------------------------------------
module smf_median (
   input  wire smf_pkg::smf_win_type win,
   output smf_pkg::sample_type       med
);
   import smf_pkg::*;

   logic [RANK_W-1:0] rank [WINDOW];

   always_comb begin
      med = '0;
      for (int i = 0; i < WINDOW; i++) begin
         rank[i] = '0;
         for (int j = 0; j < WINDOW; j++) begin
            if (j != i) begin
               if ((win[j] < win[i]) || ((win[j] == win[i]) && (j < i))) begin
                  rank[i] = rank[i] + RANK_W'(1);
               end
            end
         end
         if (rank[i] == RANK_W'(HALF)) begin
            med = win[i];
         end
      end
   end

endmodule
`default_nettype wire

FILE: src/smf_window.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// smf_window: sample history and result selection
// Holds the samples of the current scan still needed, works out the words
// that one new sample releases and updates the history when it advances.
// ---------------------------------------------------------------------------
module smf_window (
   input  wire                           clock,
   input  wire                           reset,
   input  wire                           advance,
   input  wire smf_pkg::smf_req_type     item,
   output smf_pkg::smf_rsp_vec_type      results,
   output smf_pkg::smf_fill_type         fill,
   output logic [smf_pkg::SEEN_W-1:0]    seen
);
   import smf_pkg::*;

   sample_type        hist_ff [HIST_DEPTH];
   sample_type        hist_in [HIST_DEPTH];
   logic [SEEN_W-1:0] seen_ff;
   logic [SEEN_W-1:0] seen_in;

   smf_win_type       all_s;
   sample_type        med;
   sample_type        norm_val;
   logic              has_norm;
   logic              full;
   logic [SEEN_W-1:0] first_pend;
   logic [SEEN_W-1:0] tail_n;
   logic [SEEN_W-1:0] total;
   logic [SEEN_W-1:0] slot [WINDOW];
   logic              in_tail [WINDOW];

   smf_median u_median (
      .win (all_s),
      .med (med)
   );

   // Held samples in scan order, new sample behind them
   always_comb begin
      for (int p = 0; p < HIST_DEPTH; p++) begin
         all_s[p] = (SEEN_W'(p) < seen_ff) ? hist_ff[p] : item.range_in;
      end
      all_s[HIST_DEPTH] = item.range_in;
   end

   always_comb begin
      full     = (seen_ff == SEEN_W'(HIST_DEPTH));
      has_norm = (seen_ff >= SEEN_W'(LAG));

      if (full) begin
         first_pend = SEEN_W'(HALF + 1);
      end else if (has_norm) begin
         first_pend = seen_ff - SEEN_W'(LAG) + SEEN_W'(1);
      end else begin
         first_pend = '0;
      end

      // Pass-through word while the window is still filling
      norm_val = '0;
      for (int p = 0; p < HIST_DEPTH; p++) begin
         if (has_norm && (SEEN_W'(p) == seen_ff - SEEN_W'(LAG))) begin
            norm_val = all_s[p];
         end
      end

      tail_n = item.last_in ? (seen_ff - first_pend + SEEN_W'(1)) : '0;
      total  = SEEN_W'(has_norm) + tail_n;

      results = '0;
      if (has_norm) begin
         results[0].range_out = full ? med : norm_val;
      end

      // Flush the pending samples on the final word of the scan
      for (int p = 0; p < WINDOW; p++) begin
         in_tail[p] = item.last_in && (SEEN_W'(p) >= first_pend) &&
                      (SEEN_W'(p) <= seen_ff);
         slot[p]    = SEEN_W'(p) - first_pend + SEEN_W'(has_norm);
         for (int k = 0; k < MAX_RES; k++) begin
            if (in_tail[p] && (slot[p] == SEEN_W'(k))) begin
               results[k].range_out = all_s[p];
            end
         end
      end

      for (int k = 0; k < MAX_RES; k++) begin
         results[k].last_out = item.last_in && (SEEN_W'(k + 1) == total);
      end

      fill.load  = advance;
      fill.count = CNT_W'(total);
   end

   // History update
   always_comb begin
      seen_in = seen_ff;
      for (int p = 0; p < HIST_DEPTH; p++) begin
         hist_in[p] = hist_ff[p];
      end
      if (advance) begin
         if (item.last_in) begin
            seen_in = '0;
            for (int p = 0; p < HIST_DEPTH; p++) begin
               hist_in[p] = '0;
            end
         end else if (full) begin
            for (int p = 0; p < HIST_DEPTH - 1; p++) begin
               hist_in[p] = hist_ff[p + 1];
            end
            hist_in[HIST_DEPTH-1] = item.range_in;
         end else begin
            for (int p = 0; p < HIST_DEPTH; p++) begin
               if (SEEN_W'(p) == seen_ff) begin
                  hist_in[p] = item.range_in;
               end
            end
            seen_in = seen_ff + SEEN_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff <= '0;
         for (int p = 0; p < HIST_DEPTH; p++) begin
            hist_ff[p] <= '0;
         end
      end else begin
         seen_ff <= seen_in;
         for (int p = 0; p < HIST_DEPTH; p++) begin
            hist_ff[p] <= hist_in[p];
         end
      end
   end

   assign seen = seen_ff;

endmodule
`default_nettype wire

FILE: src/smf_out_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// smf_out_queue: result register
// Takes the words released by one sample in a single load and hands them
// out one per cycle in order while rsp_stall is low.
// ---------------------------------------------------------------------------
module smf_out_queue (
   input  wire                            clock,
   input  wire                            reset,
   input  wire smf_pkg::smf_fill_type     fill,
   input  wire smf_pkg::smf_rsp_vec_type  results,
   output logic                           ready,
   output logic                           rsp_valid,
   input  wire                            rsp_stall,
   output smf_pkg::smf_rsp_type           rsp_data
);
   import smf_pkg::*;

   smf_rsp_vec_type  q_ff;
   smf_rsp_vec_type  q_in;
   logic [CNT_W-1:0] cnt_ff;
   logic [CNT_W-1:0] cnt_in;
   logic             pop;

   always_comb begin
      pop   = (cnt_ff != '0) && !rsp_stall;
      ready = (cnt_ff == '0) || ((cnt_ff == CNT_W'(1)) && pop);
      q_in   = q_ff;
      cnt_in = cnt_ff;
      if (fill.load) begin
         q_in   = results;
         cnt_in = fill.count;
      end else if (pop) begin
         // advance the queue by one word
         for (int k = 0; k < MAX_RES - 1; k++) begin
            q_in[k] = q_ff[k + 1];
         end
         cnt_in = cnt_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
      q_ff <= q_in;
   end

   assign rsp_valid = (cnt_ff != '0);
   assign rsp_data  = q_ff[0];

endmodule
`default_nettype wire

FILE: src/scan_median_filter.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// scan_median_filter: streaming 5-tap median filter for laser scans
// Replaces each range sample by the median of the five samples centred on
// it; the two samples at either end of a scan pass through unchanged.
// ---------------------------------------------------------------------------
// Takes one sample per cycle while req_stall is low. A result word leaves two
// samples behind the input, through an input register, the window and ranking
// logic and a three-word result queue. The final sample of a scan releases up
// to three words; the queue has one output port, so the input stalls while
// they drain. After the final sample the history is clear and the next scan
// starts afresh.
module scan_median_filter (
   input  wire                        clock,
   input  wire                        reset,
   input  wire                        req_valid,
   output logic                       req_stall,
   input  wire smf_pkg::smf_req_type  req_data,
   output logic                       rsp_valid,
   input  wire                        rsp_stall,
   output smf_pkg::smf_rsp_type       rsp_data
);
   import smf_pkg::*;

   logic            req_valid_ff;
   smf_req_type     req_data_ff;
   logic            q_ready;
   logic            advance;
   smf_rsp_vec_type results;
   smf_fill_type    fill;
   logic [SEEN_W-1:0] seen;

   assign advance   = req_valid_ff && q_ready;
   assign req_stall = req_valid_ff && !q_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         req_valid_ff <= req_valid;
      end
      if (!req_stall) begin
         req_data_ff <= req_data;
      end
   end

   smf_window u_window (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .item    (req_data_ff),
      .results (results),
      .fill    (fill),
      .seen    (seen)
   );

   smf_out_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .fill      (fill),
      .results   (results),
      .ready     (q_ready),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   a_seen_range: assert property (@(posedge clock) disable iff (reset)
      seen <= SEEN_W'(HIST_DEPTH))
      else $error("history count beyond window depth");

   a_last_clears: assert property (@(posedge clock) disable iff (reset)
      (advance && req_data_ff.last_in) |=> (seen == '0))
      else $error("history not cleared after final sample");

   a_last_emits: assert property (@(posedge clock) disable iff (reset)
      (advance && req_data_ff.last_in) |-> (fill.count != '0))
      else $error("final sample released no word");

   a_valid_drop: assert property (@(posedge clock) disable iff (reset)
      $fell(rsp_valid) |-> ($past(reset) || $past(!rsp_stall)))
      else $error("result word dropped while stalled");

endmodule
`default_nettype wire
